[hw/rtl/depth_pixel_back_projection_top_macros.svh]
// Assertion macros shared by the checker of the back-projection block.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_TOP_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge unless dis is high.
`define DPBP_IMPLIES(label, ck, dis, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge unless dis is high.
`define DPBP_NEXT(label, ck, dis, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dpbp_pkg.sv]
package dpbp_pkg;

  // Field and register widths.
  localparam int DEPTH_W = 20;
  localparam int REG_W   = 20;
  localparam int IDX_W   = 2;
  localparam int COLOR_W = 8;
  localparam int OUT_W   = 32;
  localparam int Z_W     = 23;

  // Fixed-point layout: Q.8 pixel offsets, depth scaled by 4096 / 1000.
  localparam int FRAC_W    = 8;
  localparam int NUM_SHIFT = 12;
  localparam int MM_PER_M  = 1000;

  // Divider geometry: quotient bits and divisor width (1000 * focal).
  localparam int QUO_W     = 32;
  localparam int DEN_W     = 30;
  localparam int DIV_STEPS = QUO_W;

  // Z = floor((depth * 4096 + 500) / 1000) = floor(((..) >> 3) / 125).
  localparam int Z_BIAS  = 500;
  localparam int ZN_W    = 32;
  localparam int Z_PRE   = 3;
  localparam int ZM_W    = ZN_W - Z_PRE;
  localparam int Z_SHIFT = 36;
  localparam int ZP_W    = 59;
  localparam logic [29:0] Z_RECIP = 30'd549755814;

  // Pipeline stage map.
  localparam int STG_IN   = 0;
  localparam int STG_MAG  = 1;
  localparam int STG_MUL  = 2;
  localparam int STG_SUM  = 3;
  localparam int STG_PREP = 4;
  localparam int STG_LAST = STG_PREP + DIV_STEPS + 1;
  localparam int NSTG     = STG_LAST + 1;

  // Saturation patterns for the signed coordinates.
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y
  } dpbp_reg_t;

  // Per-item side information carried alongside the arithmetic.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               keep;
    logic               zero;
  } dpbp_side_t;

endpackage

[hw/rtl/dpbp_if.sv]
// Pixel channel: one depth sample with its position and color.
interface dpbp_pixel_if #(parameter int COORD_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [19:0]           depth_value;
  logic                  depth_ok;
  logic [COORD_BITS-1:0] pixel_row;
  logic [COORD_BITS-1:0] pixel_col;
  logic [7:0]            blue_in;
  logic [7:0]            green_in;
  logic [7:0]            red_in;

  modport source (
    output valid, depth_value, depth_ok, pixel_row, pixel_col,
           blue_in, green_in, red_in,
    input  ready
  );
  modport sink (
    input  valid, depth_value, depth_ok, pixel_row, pixel_col,
           blue_in, green_in, red_in,
    output ready
  );
endinterface

// Point channel: one colored 3-D point.
interface dpbp_point_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [22:0]        point_z;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic               point_valid;

  modport source (
    output valid, point_x, point_y, point_z, red_out, green_out, blue_out,
           point_valid,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, red_out, green_out, blue_out,
           point_valid,
    output ready
  );
endinterface

[hw/rtl/dpbp_axis.sv]
// One image axis: depth * (coord - center) * 4096 / (1000 * focal), rounded
// to nearest on the magnitude and saturated to 32 signed bits. The quotient
// is produced by a restoring divider unrolled into one stage per bit.
module dpbp_axis import dpbp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic [NSTG-1:0]       ld,
  input  logic [DEPTH_W-1:0]    depth,
  input  logic [COORD_BITS-1:0] coord,
  input  logic [REG_W-1:0]      center,
  input  logic [REG_W-1:0]      focal,
  output logic [OUT_W-1:0]      coord_m
);

  localparam int POS_W  = COORD_BITS + FRAC_W;
  localparam int MAG_W  = (POS_W > REG_W) ? POS_W : REG_W;
  localparam int PROD_W = DEPTH_W + MAG_W;
  localparam int NUM_W  = PROD_W + NUM_SHIFT + 1;
  localparam int HI_W   = NUM_W - QUO_W;

  logic [DEN_W-1:0]   den;
  logic [POS_W-1:0]   pos;
  logic [MAG_W-1:0]   pos_ext;
  logic [MAG_W-1:0]   ctr_ext;
  logic               neg_c;
  logic [MAG_W-1:0]   mag_c;
  logic               neg1, neg2, neg3;
  logic [MAG_W-1:0]   mag1;
  logic [DEPTH_W-1:0] depth1;
  logic [PROD_W-1:0]  prod2;
  logic [NUM_W-1:0]   nsum3;
  logic [HI_W-1:0]    hi3;
  logic [DEN_W-1:0]   p_s  [0:DIV_STEPS];
  logic [QUO_W-1:0]   lq_s [0:DIV_STEPS];
  logic               neg_s[0:DIV_STEPS];
  logic               big_s[0:DIV_STEPS];
  logic [QUO_W-1:0]   quo;
  logic               sat;
  logic [OUT_W-1:0]   res;

  // Divisor tracks focal; user keeps it stable while items flow, unchecked.
  always_ff @(posedge clk) begin
    den <= DEN_W'(focal) * DEN_W'(MM_PER_M);
  end

  // Stage 1: signed pixel offset as sign and magnitude.
  always_comb begin
    pos     = {coord, FRAC_W'(0)};
    pos_ext = MAG_W'(pos);
    ctr_ext = MAG_W'(center);
    neg_c   = pos_ext < ctr_ext;
    mag_c   = neg_c ? (ctr_ext - pos_ext) : (pos_ext - ctr_ext);
  end

  always_ff @(posedge clk) begin
    if (ld[STG_MAG]) begin
      neg1   <= neg_c;
      mag1   <= mag_c;
      depth1 <= depth;
    end
  end

  // Stage 2: depth times offset magnitude.
  always_ff @(posedge clk) begin
    if (ld[STG_MUL]) begin
      neg2  <= neg1;
      prod2 <= PROD_W'(depth1) * PROD_W'(mag1);
    end
  end

  // Stage 3: scale by 4096 and add half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (ld[STG_SUM]) begin
      neg3  <= neg2;
      nsum3 <= NUM_W'({prod2, NUM_SHIFT'(0)}) + NUM_W'(den >> 1);
    end
  end

  // Stage 4: a quotient of 2^32 or more shows in the upper bits alone.
  assign hi3 = nsum3[NUM_W-1:QUO_W];

  always_ff @(posedge clk) begin
    if (ld[STG_PREP]) begin
      neg_s[0] <= neg3;
      big_s[0] <= DEN_W'(hi3) >= den;
      p_s[0]   <= DEN_W'(hi3);
      lq_s[0]  <= nsum3[QUO_W-1:0];
    end
  end

  // Divider stages: shift in one dividend bit, subtract when it fits.
  for (genvar d = 1; d <= DIV_STEPS; d++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {p_s[d-1], lq_s[d-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (ld[STG_PREP + d]) begin
        neg_s[d] <= neg_s[d-1];
        big_s[d] <= big_s[d-1];
        p_s[d]   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lq_s[d]  <= {lq_s[d-1][QUO_W-2:0], fits};
      end
    end
  end

  // Final stage: apply the sign and saturate.
  assign quo = lq_s[DIV_STEPS];

  always_comb begin
    if (neg_s[DIV_STEPS]) begin
      sat = big_s[DIV_STEPS] || (quo[QUO_W-1] && (quo[QUO_W-2:0] != '0));
      res = sat ? SAT_NEG : OUT_W'(QUO_W'(0) - quo);
    end else begin
      sat = big_s[DIV_STEPS] || quo[QUO_W-1];
      res = sat ? SAT_POS : OUT_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[STG_LAST]) begin
      coord_m <= res;
    end
  end

endmodule

[hw/rtl/depth_pixel_back_projection_top.sv]
// Back-projects a stream of depth pixels through a pinhole camera model into
// colored points (x, y, z in meters, units of 2^-12). One pixel is taken per
// clock unless the output holds the pipeline back. The restoring divider that
// forms x and y has 32 one-bit stages, with the input, offset, multiply,
// rounding, range-check and saturation stages around it. Every stage holds
// its item under backpressure and takes a new one as soon as it frees up, so
// the pipeline keeps filling while the output waits. Program the four
// intrinsics (focal_x, focal_y, center_x, center_y) only with no points in
// flight; they reset to zero, which makes every pixel a valid zero point.
module depth_pixel_back_projection_top import dpbp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0] wr_data,
  dpbp_pixel_if.sink       pix,
  dpbp_point_if.source     pnt
);

  logic [REG_W-1:0]      focal_x;
  logic [REG_W-1:0]      focal_y;
  logic [REG_W-1:0]      center_x;
  logic [REG_W-1:0]      center_y;
  logic [NSTG-1:0]       v;
  logic [NSTG-1:0]       ld;
  logic                  all_zero;
  logic                  bad;
  dpbp_side_t            side_c;
  dpbp_side_t            side_s[STG_IN:STG_LAST];
  logic [DEPTH_W-1:0]    depth0;
  logic [COORD_BITS-1:0] row0;
  logic [COORD_BITS-1:0] col0;
  logic [ZN_W-1:0]       zn;
  logic [ZM_W-1:0]       zm1;
  logic [ZP_W-1:0]       zp2;
  logic [Z_W-1:0]        zs[STG_SUM:STG_LAST];
  logic [OUT_W-1:0]      x_m;
  logic [OUT_W-1:0]      y_m;
  dpbp_side_t            side_o;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= '0;
      focal_y  <= '0;
      center_x <= '0;
      center_y <= '0;
    end else if (wr_en) begin
      unique case (dpbp_reg_t'(wr_index))
        REG_FOCAL_X:  focal_x  <= wr_data;
        REG_FOCAL_Y:  focal_y  <= wr_data;
        REG_CENTER_X: center_x <= wr_data;
        REG_CENTER_Y: center_y <= wr_data;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  assign ld[STG_LAST] = !v[STG_LAST] || pnt.ready;
  for (genvar k = 0; k < STG_LAST; k++) begin : g_ld
    assign ld[k] = !v[k] || ld[k+1];
  end

  assign pix.ready = ld[STG_IN];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[STG_IN]) begin
        v[STG_IN] <= pix.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Classify the pixel: pass-through for blank intrinsics, else reject it on a bad depth or a zero focal length.
  always_comb begin
    all_zero     = (focal_x == '0) && (focal_y == '0) &&
                   (center_x == '0) && (center_y == '0);
    bad          = !pix.depth_ok || (focal_x == '0) || (focal_y == '0);
    side_c.keep  = all_zero || !bad;
    side_c.zero  = all_zero || bad;
    side_c.red   = side_c.keep ? pix.red_in   : '0;
    side_c.green = side_c.keep ? pix.green_in : '0;
    side_c.blue  = side_c.keep ? pix.blue_in  : '0;
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (ld[STG_IN]) begin
      depth0         <= pix.depth_value;
      row0           <= pix.pixel_row;
      col0           <= pix.pixel_col;
      side_s[STG_IN] <= side_c;
    end
  end

  // Side information delay line.
  for (genvar k = STG_IN + 1; k <= STG_LAST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        side_s[k] <= side_s[k-1];
      end
    end
  end

  // Z: divide by 1000 as a divide by 8 then a reciprocal multiply by 1/125.
  assign zn = {depth0, NUM_SHIFT'(0)} + ZN_W'(Z_BIAS);

  always_ff @(posedge clk) begin
    if (ld[STG_MAG]) begin
      zm1 <= zn[ZN_W-1:Z_PRE];
    end
    if (ld[STG_MUL]) begin
      zp2 <= ZP_W'(zm1) * ZP_W'(Z_RECIP);
    end
    if (ld[STG_SUM]) begin
      zs[STG_SUM] <= zp2[Z_SHIFT +: Z_W];
    end
  end

  for (genvar k = STG_SUM + 1; k <= STG_LAST; k++) begin : g_z
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        zs[k] <= zs[k-1];
      end
    end
  end

  // X from the column, Y from the row.
  dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk     (clk),
    .ld      (ld),
    .depth   (depth0),
    .coord   (col0),
    .center  (center_x),
    .focal   (focal_x),
    .coord_m (x_m)
  );

  dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk     (clk),
    .ld      (ld),
    .depth   (depth0),
    .coord   (row0),
    .center  (center_y),
    .focal   (focal_y),
    .coord_m (y_m)
  );

  // Output beat.
  assign side_o          = side_s[STG_LAST];
  assign pnt.valid       = v[STG_LAST];
  assign pnt.point_x     = side_o.zero ? '0 : $signed(x_m);
  assign pnt.point_y     = side_o.zero ? '0 : $signed(y_m);
  assign pnt.point_z     = side_o.zero ? '0 : zs[STG_LAST];
  assign pnt.red_out     = side_o.red;
  assign pnt.green_out   = side_o.green;
  assign pnt.blue_out    = side_o.blue;
  assign pnt.point_valid = side_o.keep;

endmodule

[hw/rtl/dpbp_checker.sv]
`include "depth_pixel_back_projection_top_macros.svh"

// Port-level checks of the back-projection block.
module dpbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [22:0] out_z,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_point_valid
);

  localparam logic [22:0] Z_MAX = 23'd4294963;

  logic [111:0] out_beat;
  logic         out_stall;
  logic         out_dropped;
  logic         zero_point;

  // Whole output payload, and the conditions the checks key on.
  assign out_beat    = {out_x, out_y, out_z, out_red, out_green, out_blue, out_point_valid};
  assign out_stall   = out_valid && !out_ready;
  assign out_dropped = out_valid && !out_point_valid;
  assign zero_point  = (out_x == 32'd0) && (out_y == 32'd0) && (out_z == 23'd0) &&
                       (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0);

  // A stalled output beat keeps its payload.
  `DPBP_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_beat), "held beat changed")

  // Reset empties the pipeline.
  `DPBP_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "point beat right after reset")

  // With nothing at the output, every stage can load, so input is taken.
  `DPBP_IMPLIES(a_drain_ready, clk, rst, !out_valid, in_ready, "input stalled on empty output")

  // An invalid point is all zero.
  `DPBP_IMPLIES(a_invalid_zero, clk, rst, out_dropped, zero_point, "invalid point not zero")

  // Depth in meters stays within its largest value whenever an output beat meets an input beat.
  `DPBP_IMPLIES(a_z_range, clk, rst, out_valid && in_valid, out_z <= Z_MAX, "depth out of range")

endmodule

bind depth_pixel_back_projection_top dpbp_checker u_dpbp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (pix.valid),
  .in_ready        (pix.ready),
  .out_valid       (pnt.valid),
  .out_ready       (pnt.ready),
  .out_x           (pnt.point_x),
  .out_y           (pnt.point_y),
  .out_z           (pnt.point_z),
  .out_red         (pnt.red_out),
  .out_green       (pnt.green_out),
  .out_blue        (pnt.blue_out),
  .out_point_valid (pnt.point_valid)
);
